### rtl/xee_pkg.sv
// Package for the XML entity escape unit: payload structs, command codes,
// character constants and the entity spelling functions.
// Depends on nothing; used by every other file of the block but xee_fifo.
package xee_pkg;

   // Default queue depths, handed to the top level parameters.
   localparam int CMD_DEPTH_DEF = 4;
   localparam int RSP_DEPTH_DEF = 2;

   // Input item and result item as they cross the ports.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Prefix that a held "&" or "&#" turns into.
   typedef logic [1:0] pfx_type;
   localparam pfx_type PFX_NONE    = 2'd0;
   localparam pfx_type PFX_AMP     = 2'd1;  // "&amp;"
   localparam pfx_type PFX_AMPHASH = 2'd2;  // "&amp;#"
   localparam pfx_type PFX_HASHX   = 2'd3;  // "&#x"

   // Expansion of the current byte itself.
   typedef logic [2:0] body_type;
   localparam body_type BODY_NONE = 3'd0;
   localparam body_type BODY_LIT  = 3'd1;
   localparam body_type BODY_AMP  = 3'd2;
   localparam body_type BODY_LT   = 3'd3;
   localparam body_type BODY_GT   = 3'd4;
   localparam body_type BODY_QUOT = 3'd5;
   localparam body_type BODY_APOS = 3'd6;
   localparam body_type BODY_HEX  = 3'd7;

   // One classified item, passed from the front to the expander.
   typedef struct packed {
      pfx_type    pfx;
      body_type   body;
      logic [7:0] text_byte;
      logic       last;
   } cmd_type;

   // Characters that the classifier and the expander both need.
   localparam logic [7:0] CH_AMP   = "&";
   localparam logic [7:0] CH_HASH  = "#";
   localparam logic [7:0] CH_X     = "x";
   localparam logic [7:0] CH_SEMI  = ";";
   localparam logic [7:0] CH_LT    = "<";
   localparam logic [7:0] CH_GT    = ">";
   localparam logic [7:0] CH_QUOTE = "\"";
   localparam logic [7:0] CH_APOS  = "'";
   localparam logic [7:0] PRINT_LO = 8'd32;
   localparam logic [7:0] PRINT_HI = 8'd126;

   // Number of bytes a prefix expands to.
   function automatic logic [2:0] pfx_len(input pfx_type p);
      logic [2:0] len;
      unique case (p)
         PFX_NONE:    len = 3'd0;
         PFX_AMP:     len = 3'd5;
         PFX_AMPHASH: len = 3'd6;
         default:     len = 3'd3;
      endcase
      return len;
   endfunction

   // Number of bytes a body expands to.
   function automatic logic [2:0] body_len(input body_type b);
      logic [2:0] len;
      unique case (b) inside
         BODY_NONE:                     len = 3'd0;
         BODY_LIT:                      len = 3'd1;
         BODY_AMP:                      len = 3'd5;
         BODY_LT, BODY_GT:              len = 3'd4;
         BODY_QUOT, BODY_APOS, BODY_HEX: len = 3'd6;
         default:                       len = 3'd0;
      endcase
      return len;
   endfunction

   // Upper-case hex digit of a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) c = 8'h30 + {4'h0, n};
      else           c = 8'h37 + {4'h0, n};
      return c;
   endfunction

   // Spelling of "&amp;".
   function automatic logic [7:0] amp_char(input logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0:    c = CH_AMP;
         3'd1:    c = "a";
         3'd2:    c = "m";
         3'd3:    c = "p";
         default: c = CH_SEMI;
      endcase
      return c;
   endfunction

   // Byte i of a prefix.
   function automatic logic [7:0] pfx_char(input pfx_type p, input logic [2:0] i);
      logic [7:0] c;
      if (p == PFX_HASHX) begin
         case (i)
            3'd0:    c = CH_AMP;
            3'd1:    c = CH_HASH;
            default: c = CH_X;
         endcase
      end else if (p == PFX_AMPHASH && i == 3'd5) begin
         c = CH_HASH;
      end else begin
         c = amp_char(i);
      end
      return c;
   endfunction

   // Byte i of a body for the text byte b.
   function automatic logic [7:0] body_char(input body_type bd, input logic [2:0] i,
                                            input logic [7:0] b);
      logic [7:0] c;
      c = CH_SEMI;
      if (i == 3'd0) begin
         c = (bd == BODY_LIT) ? b : CH_AMP;
      end else begin
         unique case (bd)
            BODY_AMP: c = amp_char(i);
            BODY_LT:  c = (i == 3'd1) ? "l" : (i == 3'd2) ? "t" : CH_SEMI;
            BODY_GT:  c = (i == 3'd1) ? "g" : (i == 3'd2) ? "t" : CH_SEMI;
            BODY_QUOT: begin
               case (i)
                  3'd1:    c = "q";
                  3'd2:    c = "u";
                  3'd3:    c = "o";
                  3'd4:    c = "t";
                  default: c = CH_SEMI;
               endcase
            end
            BODY_APOS: begin
               case (i)
                  3'd1:    c = "a";
                  3'd2:    c = "p";
                  3'd3:    c = "o";
                  3'd4:    c = "s";
                  default: c = CH_SEMI;
               endcase
            end
            BODY_HEX: begin
               case (i)
                  3'd1:    c = CH_HASH;
                  3'd2:    c = CH_X;
                  3'd3:    c = hex_digit(b[7:4]);
                  3'd4:    c = hex_digit(b[3:0]);
                  default: c = CH_SEMI;
               endcase
            end
            default: c = b;
         endcase
      end
      return c;
   endfunction

endpackage

### rtl/xee_fifo.sv
// Small synchronous queue with a registered array and first-word output.
// Depends on nothing; used for the command queue and the result queue.
module xee_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   // Pointer and occupancy update for each transfer.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop_ok)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push_ok && !pop_ok) count_in = count_ff + 1'b1;
      else if (pop_ok && !push_ok) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; entries are read only after being written.
   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= wdata;
   end

endmodule

### rtl/xee_front.sv
// Front end of the escape unit: tracks held "&" / "&#" and raw references,
// and turns each accepted byte into at most one expansion command.
// Depends on xee_pkg.
module xee_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  xee_pkg::req_type req,
   output logic             cmd_push,
   output xee_pkg::cmd_type cmd
);
   import xee_pkg::*;

   localparam logic [1:0] HELD_NONE    = 2'd0;
   localparam logic [1:0] HELD_AMP     = 2'd1;
   localparam logic [1:0] HELD_AMPHASH = 2'd2;

   logic [1:0] held_ff, held_in;
   logic       raw_ff, raw_in;
   logic [7:0] b;
   logic       last;
   body_type   esc_body, plain_body, body;
   pfx_type    pfx;
   logic       plain_hold;

   assign b    = req.text_byte;
   assign last = req.end_of_text;

   // Plain escaping class of the byte.
   always_comb begin
      if (b == CH_AMP)                       esc_body = BODY_AMP;
      else if (b == CH_LT)                   esc_body = BODY_LT;
      else if (b == CH_GT)                   esc_body = BODY_GT;
      else if (b == CH_QUOTE)                esc_body = BODY_QUOT;
      else if (b == CH_APOS)                 esc_body = BODY_APOS;
      else if (b < PRINT_LO || b > PRINT_HI) esc_body = BODY_HEX;
      else                                   esc_body = BODY_LIT;
   end

   // An ampersand that is not the last byte is held for look-ahead.
   assign plain_hold = (b == CH_AMP) && !last;
   assign plain_body = plain_hold ? BODY_NONE : esc_body;

   // Next state and command for the accepted byte.
   always_comb begin
      pfx     = PFX_NONE;
      body    = BODY_NONE;
      held_in = held_ff;
      raw_in  = raw_ff;
      if (accept) begin
         if (raw_ff) begin
            body = BODY_LIT;
            if (b == CH_SEMI) raw_in = 1'b0;
         end else if (held_ff == HELD_NONE) begin
            body    = plain_body;
            held_in = plain_hold ? HELD_AMP : HELD_NONE;
         end else if (held_ff == HELD_AMP) begin
            if (b == CH_HASH) begin
               if (last) begin
                  pfx     = PFX_AMPHASH;
                  held_in = HELD_NONE;
               end else begin
                  held_in = HELD_AMPHASH;
               end
            end else begin
               pfx     = PFX_AMP;
               body    = plain_body;
               held_in = plain_hold ? HELD_AMP : HELD_NONE;
            end
         end else begin
            if (b == CH_X) begin
               pfx     = PFX_HASHX;
               raw_in  = 1'b1;
               held_in = HELD_NONE;
            end else begin
               pfx     = PFX_AMPHASH;
               body    = plain_body;
               held_in = plain_hold ? HELD_AMP : HELD_NONE;
            end
         end
         // End of text flushes everything and leaves raw mode.
         if (last) begin
            held_in = HELD_NONE;
            raw_in  = 1'b0;
         end
      end
   end

   assign cmd_push      = accept && (pfx != PFX_NONE || body != BODY_NONE);
   assign cmd.pfx       = pfx;
   assign cmd.body      = body;
   assign cmd.text_byte = b;
   assign cmd.last      = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
         raw_ff  <= 1'b0;
      end else begin
         held_ff <= held_in;
         raw_ff  <= raw_in;
      end
   end

endmodule

### rtl/xee_back.sv
// Back end of the escape unit: spells out one command a byte per cycle into
// the result queue while it has room. Depends on xee_pkg and xee_fifo.
module xee_back #(
   parameter int RSP_DEPTH = xee_pkg::RSP_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  xee_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output xee_pkg::rsp_type rsp_data
);
   import xee_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic [2:0] plen, blen, bidx;
   logic [3:0] total;
   logic       in_pfx, done, emit, out_full;
   rsp_type    out_item;

   // Position within the expanded command.
   assign plen   = pfx_len(cmd.pfx);
   assign blen   = body_len(cmd.body);
   assign total  = {1'b0, plen} + {1'b0, blen};
   assign in_pfx = idx_ff < {1'b0, plen};
   assign bidx   = 3'(idx_ff - {1'b0, plen});
   assign done   = (idx_ff == total - 4'd1);
   assign emit   = cmd_valid && !out_full;
   assign cmd_pop = emit && done;

   assign out_item.out_byte = in_pfx ? pfx_char(cmd.pfx, idx_ff[2:0])
                                     : body_char(cmd.body, bidx, cmd.text_byte);
   assign out_item.out_last = cmd.last && done;

   // Step through the bytes; restart at zero for the next command.
   always_comb begin
      idx_in = idx_ff;
      if (emit) idx_in = done ? 4'd0 : idx_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 4'd0;
      else       idx_ff <= idx_in;
   end

   // Result queue decouples the expander from the consumer.
   logic [$bits(rsp_type)-1:0] rsp_bits;

   xee_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push (emit),
      .wdata(out_item),
      .full (out_full),
      .pop  (rsp_pop),
      .empty(rsp_empty),
      .rdata(rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

### rtl/xml_entity_escape_unit.sv
// Top level of the XML entity escape unit: classifier front end, command
// queue and byte expander. Depends on xee_pkg, xee_front, xee_fifo, xee_back.
//
//   Channel   Ports                       Moves
//   input     req_push/req_full/req_data  one text byte with end marker
//   result    rsp_pop/rsp_empty/rsp_data  one escaped byte with last flag
//
// Throughput is one result byte per cycle while the result queue has room,
// set by the expander; an item expands to N bytes (0 to 12).
// An item that makes one byte is taken every cycle while the command queue
// is not full; its command is written into the command queue and its byte
// into the result queue before the result is on the result ports.
// req_full rises when the command queue (CMD_DEPTH entries) is full, so
// long entities or a stalled consumer push back on the input.
// Synchronous reset empties both queues and clears the held and raw state.
module xml_entity_escape_unit #(
   parameter int CMD_DEPTH = xee_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = xee_pkg::RSP_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  xee_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output xee_pkg::rsp_type rsp_data
);
   import xee_pkg::*;

   logic                       accept, cmd_push, cmd_pop, cmd_empty;
   cmd_type                    cmd_new, cmd_head;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   assign accept = req_push && !req_full;

   // Classifier.
   xee_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .cmd_push(cmd_push),
      .cmd     (cmd_new)
   );

   // Command queue between classifier and expander.
   xee_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock(clock),
      .reset(reset),
      .push (cmd_push),
      .wdata(cmd_new),
      .full (req_full),
      .pop  (cmd_pop),
      .empty(cmd_empty),
      .rdata(cmd_bits)
   );

   assign cmd_head = cmd_type'(cmd_bits);

   // Expander and result queue.
   xee_back #(
      .RSP_DEPTH(RSP_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(!cmd_empty),
      .cmd      (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/xee_checker.sv
// Port-level checks for the XML entity escape unit, bound to the top level.
// Depends on xee_pkg and xml_entity_escape_unit.
module xee_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input xee_pkg::req_type req_data,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input xee_pkg::rsp_type rsp_data
);
   import xee_pkg::*;

   // Reset leaves both queues empty.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting result is held until it is transferred.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(!rsp_empty && !rsp_pop)) |-> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed before transfer");

   // The command queue fills only through an input transfer.
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(req_full)) |-> $past(req_push && !req_full))
      else $error("full rose without an input transfer");

   // Nothing is invented: the result queue stays empty straight after reset.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(reset, 2) && $fell(rsp_empty)) |-> 1'b0)
      else $error("result appeared too early after reset");

endmodule

bind xml_entity_escape_unit xee_checker u_xee_checker (
   .clock    (clock),
   .reset    (reset),
   .req_push (req_push),
   .req_full (req_full),
   .req_data (req_data),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data)
);

### bench/xml_entity_escape_unit_tb.sv
// Self-checking testbench for xml_entity_escape_unit: a queue-fed driver, a
// checking monitor and a cycle-free escaper predictor built into the bench.
// Depends on xee_pkg and the xml_entity_escape_unit RTL.
module xml_entity_escape_unit_tb;
   import xee_pkg::*;

   // States of the look-ahead on a leading ampersand.
   localparam logic [1:0] HELD_NONE    = 2'd0;
   localparam logic [1:0] HELD_AMP     = 2'd1;
   localparam logic [1:0] HELD_AMPHASH = 2'd2;

   localparam int RANDOM_ITEMS   = 415;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 200;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int DRAIN_CYCLES   = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    rsp_pop   = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   // Items waiting to be offered and escaped bytes waiting to arrive.
   req_type pending_items[$];
   rsp_type escaped_expected[$];
   rsp_type step_bytes[$];
   logic [7:0] text_buf[$];

   // Predictor state.
   logic [1:0] held_cnt;
   logic       in_raw_ref;

   int unsigned items_sent = 0;
   int unsigned texts_built = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned full_stall_cycles = 0;

   xml_entity_escape_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Escaper predictor.
   function automatic void put_byte(logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.out_last = 1'b0;
      step_bytes.push_back(r);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_escaped(logic [7:0] b);
      string hex_chars;
      hex_chars = "0123456789ABCDEF";
      case (b)
         CH_AMP:   put_text("&amp;");
         CH_LT:    put_text("&lt;");
         CH_GT:    put_text("&gt;");
         CH_QUOTE: put_text("&quot;");
         CH_APOS:  put_text("&apos;");
         default: begin
            if (b < PRINT_LO || b > PRINT_HI) begin
               put_text("&#x");
               put_byte(hex_chars[b[7:4]]);
               put_byte(hex_chars[b[3:0]]);
               put_byte(CH_SEMI);
            end else begin
               put_byte(b);
            end
         end
      endcase
   endfunction

   // A byte seen with nothing held and outside a raw reference.
   function automatic void put_plain(logic [7:0] b, logic last);
      if (b == CH_AMP && !last) held_cnt = HELD_AMP;
      else put_escaped(b);
   endfunction

   function automatic void predict_transfer(req_type item);
      logic [7:0] b;
      logic       last;
      b = item.text_byte;
      last = item.end_of_text;
      step_bytes.delete();
      if (in_raw_ref) begin
         put_byte(b);
         if (b == CH_SEMI) in_raw_ref = 1'b0;
      end else if (held_cnt == HELD_NONE) begin
         put_plain(b, last);
      end else if (held_cnt == HELD_AMP) begin
         held_cnt = HELD_NONE;
         if (b == CH_HASH) begin
            if (last) put_text("&amp;#");
            else held_cnt = HELD_AMPHASH;
         end else begin
            put_text("&amp;");
            put_plain(b, last);
         end
      end else begin
         held_cnt = HELD_NONE;
         if (b == CH_X) begin
            put_text("&#x");
            in_raw_ref = 1'b1;
         end else begin
            put_text("&amp;#");
            put_plain(b, last);
         end
      end
      if (last) begin
         held_cnt = HELD_NONE;
         in_raw_ref = 1'b0;
         if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].out_last = 1'b1;
      end
      foreach (step_bytes[i]) escaped_expected.push_back(step_bytes[i]);
   endfunction

   // Stimulus construction.
   function automatic void add_item(logic [7:0] b, logic e);
      req_type it;
      it.text_byte = b;
      it.end_of_text = e;
      pending_items.push_back(it);
   endfunction

   function automatic void add_string(string s, logic end_last);
      for (int i = 0; i < s.len(); i++) add_item(s[i], end_last && (i == s.len() - 1));
   endfunction

   function automatic logic [7:0] pick_special();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0:       c = CH_AMP;
         1:       c = CH_LT;
         2:       c = CH_GT;
         3:       c = CH_QUOTE;
         default: c = CH_APOS;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pick_unprintable();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(0, 31));
      else c = 8'($urandom_range(127, 255));
      return c;
   endfunction

   // One text of random tokens, most of them well formed, ending in the marker.
   function automatic void add_random_text();
      int unsigned tokens;
      int unsigned kind;
      int unsigned ref_len;
      string digits;
      digits = "0123456789abcdefABCDEF";
      text_buf.delete();
      tokens = $urandom_range(1, 12);
      for (int t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            text_buf.push_back(8'($urandom_range(32, 126)));
         end else if (kind < 45) begin
            text_buf.push_back(pick_special());
         end else if (kind < 55) begin
            text_buf.push_back(pick_unprintable());
         end else if (kind < 75) begin
            // A raw hex reference, sometimes with odd content or no closing semicolon.
            text_buf.push_back(CH_AMP);
            text_buf.push_back(CH_HASH);
            text_buf.push_back(CH_X);
            ref_len = $urandom_range(1, 4);
            for (int k = 0; k < ref_len; k++) begin
               if ($urandom_range(0, 6) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
               else text_buf.push_back(digits[$urandom_range(0, digits.len() - 1)]);
            end
            if ($urandom_range(0, 4) != 0) text_buf.push_back(CH_SEMI);
         end else if (kind < 83) begin
            text_buf.push_back(CH_AMP);
            text_buf.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 90) begin
            text_buf.push_back(CH_AMP);
            text_buf.push_back(CH_HASH);
            text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (text_buf[i]) add_item(text_buf[i], i == text_buf.size() - 1);
      texts_built++;
   endfunction

   function automatic void build_directed();
      // Field extremes and the printable boundaries.
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(8'h1F, 1'b0);
      add_item(8'h20, 1'b0);
      add_item(8'h7E, 1'b0);
      add_item(8'h7F, 1'b0);
      // The named entities other than the ampersand.
      add_item(CH_LT, 1'b0);
      add_item(CH_GT, 1'b0);
      add_item(CH_QUOTE, 1'b0);
      add_item(CH_APOS, 1'b0);
      // Held ampersand followed by another ampersand, then a broken "&#".
      add_string("&&#y", 1'b0);
      // Raw reference carrying a control byte and an ampersand.
      add_string("&#x", 1'b0);
      add_item(8'h01, 1'b0);
      add_string("&;", 1'b0);
      // Ampersand as the last byte, and "&#" cut by the end marker.
      add_string("&", 1'b1);
      add_string("&#", 1'b1);
      // "&#x" closed by the end marker, then "&#" followed by a new ampersand.
      add_string("&#x", 1'b1);
      add_string("&#&q", 1'b1);
      // Text that ends inside a raw reference.
      add_string("&#xZ", 1'b1);
      texts_built += 5;
   endfunction

   // Gap lengths: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      int unsigned g;
      r = $urandom_range(0, 99);
      if (r < 55) g = 0;
      else if (r < 92) g = $urandom_range(1, 3);
      else g = $urandom_range(8, 30);
      return g;
   endfunction

   // Driver: offers the oldest pending item and predicts it on transfer.
   int unsigned send_gap = 0;
   int unsigned send_phase = 0;
   logic        send_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            predict_transfer(req_data);
            void'(pending_items.pop_front());
            items_sent++;
            send_gap = send_calm ? 0 : pick_gap();
         end
         if (req_push && req_full) begin
            full_stall_cycles++;
         end else if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_push <= 1'b1;
            req_data <= pending_items[0];
         end else begin
            req_push <= 1'b0;
         end
         // Alternate between idling and back-to-back stretches.
         if (send_phase == 0) begin
            send_calm = ($urandom_range(0, 2) == 0);
            send_phase = $urandom_range(20, 80);
         end else begin
            send_phase--;
         end
      end
   end

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (escaped_expected.size() == 0) begin
         $error("unexpected result: out_byte 8'h%02h out_last %0b", got.out_byte, got.out_last);
         mismatches++;
      end else begin
         want = escaped_expected.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected 8'h%02h, actual 8'h%02h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
            mismatches++;
         end
      end
      results_checked++;
   endfunction

   // Monitor: pops with random stalls and one long hold-off to fill the block.
   int unsigned pop_gap = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned recv_phase = 0;
   logic        recv_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = recv_calm ? 0 : pick_gap();
         end
         if (recv_phase == 0) begin
            recv_calm = ($urandom_range(0, 2) == 0);
            recv_phase = $urandom_range(20, 80);
         end else begin
            recv_phase--;
         end
      end
   end

   // Sequence: build stimulus, wait for it to drain, then report.
   initial begin
      int unsigned drain_wait;
      int unsigned directed_count;
      held_cnt = HELD_NONE;
      in_raw_ref = 1'b0;
      build_directed();
      directed_count = pending_items.size();
      while (pending_items.size() < directed_count + RANDOM_ITEMS) add_random_text();

      wait (!reset);
      while (pending_items.size() > 0) @(posedge clock);
      drain_wait = 0;
      while (escaped_expected.size() > 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (escaped_expected.size() > 0) begin
         $error("%0d escaped bytes never arrived", escaped_expected.size());
         mismatches += escaped_expected.size();
      end

      $display("Escaped %0d texts (%0d bytes in), checked %0d bytes out.",
               texts_built, items_sent, results_checked);
      $display("Input was held off by a full queue on %0d cycles.", full_stall_cycles);
      if (mismatches == 0) begin
         $display("xml_entity_escape_unit_tb passed");
      end else begin
         $display("xml_entity_escape_unit_tb failed");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #3000000;
      $display("xml_entity_escape_unit_tb failed");
      $finish;
   end

endmodule
